/* design/mt19937_generator_defines.svh */
// Assertion macros used by the generator RTL.
`ifndef MT19937_GENERATOR_DEFINES_SVH
`define MT19937_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define MT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mt19937 check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define MT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mt19937 check failed");

`endif

/* design/mt_pkg.sv */
`default_nettype none

package mt_pkg;

    localparam int WORD_W       = 32;
    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int IDX_W        = $clog2(STATE_WORDS);

    localparam logic [WORD_W-1:0] INIT_MULT  = 32'h6c078965;
    localparam logic [WORD_W-1:0] UPPER_MASK = 32'h80000000;
    localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fffffff;
    localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908b0df;
    localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc60000;

    localparam logic [WORD_W-1:0] DEFAULT_SEED_RESET = 32'd5489;

    // Action codes carried in tuser.
    localparam logic ACT_EXTRACT = 1'b0;
    localparam logic ACT_SEED    = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

endpackage

`default_nettype wire

/* design/mt_cell.sv */
`default_nettype none

// One state word of the ring; loads its neighbor's word on a shift.
module mt_cell
    import mt_pkg::*;
(
    input  wire   clk,
    input  wire   shift,
    input  word_t din,
    output word_t dout
);

    word_t word_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            word_reg <= din;
        end
    end

    assign dout = word_reg;

endmodule

`default_nettype wire

/* design/mt_twist.sv */
`default_nettype none

// Twist the head word with its successor and the far tap, then temper.
module mt_twist
    import mt_pkg::*;
(
    input  word_t cur_word,
    input  word_t next_word,
    input  word_t far_word,
    output word_t twisted,
    output word_t tempered
);

    word_t y;
    word_t t0;
    word_t t1;
    word_t t2;

    always_comb
    begin
        y = (cur_word & UPPER_MASK) | (next_word & LOWER_MASK);
        twisted = far_word ^ (y >> 1);
        if (y[0])
        begin
            twisted = twisted ^ MATRIX_A;
        end
        t0 = twisted ^ (twisted >> 11);
        t1 = t0 ^ ((t0 << 7) & TEMPER_B);
        t2 = t1 ^ ((t1 << 15) & TEMPER_C);
        tempered = t2 ^ (t2 >> 18);
    end

endmodule

`default_nettype wire

/* design/mt19937_generator.sv */
// MT19937 generator: a ring of 624 word cells that rotates once per word.
// Extract: one word per cycle when not stalled or seeding; the tempered word is
// registered, so it shows in the cycle after acceptance. Seed: one word per cycle
// into the tail cell via the seeding multiplier; an unseeded extract seeds first.
// Reset (rst_n, async, active low) clears control only: unseeded, default seed
// 5489, output empty. The state cells are not cleared and need no clearing pass.
`default_nettype none

`include "mt19937_generator_defines.svh"

module mt19937_generator
    import mt_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,    // [31:0] seed_value
    input  wire         s_tuser,    // [0] action: 1 = seed, 0 = extract
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // [31:0] random_word
    // default seed register write
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [31:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,   // take items, extract in place
        ST_SEED = 3'b010,   // stream the seeded words into the ring
        ST_PEND = 3'b100    // extract held back by an implicit seed
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] seed_cnt_reg, seed_cnt_next;
    word_t            seed_reg, seed_next;
    logic             pend_reg, pend_next;
    logic             seeded_reg, seeded_next;
    word_t            default_seed_reg;
    logic             m_tvalid_reg;
    word_t            m_tdata_reg;

    word_t cell_word [STATE_WORDS];
    word_t tail_in;
    word_t twisted;
    word_t tempered;
    word_t tail_mix;
    word_t seed_word;
    logic  s_accept;
    logic  out_free;
    logic  do_extract;
    logic  shift_en;

    // ------------------------------------------------------------------
    // Ring of cells. Cell 0 always holds the word in use, cell 1 its
    // successor and cell TWIST_OFFSET the far tap; a shift rotates the
    // ring by one word, so the word index lives in the ring position.
    // ------------------------------------------------------------------
    genvar k;
    generate
        for (k = 0; k < STATE_WORDS; k++)
        begin : g_cell
            if (k == STATE_WORDS - 1)
            begin : g_tail
                mt_cell u_cell (
                    .clk   (clk),
                    .shift (shift_en),
                    .din   (tail_in),
                    .dout  (cell_word[k])
                );
            end
            else
            begin : g_body
                mt_cell u_cell (
                    .clk   (clk),
                    .shift (shift_en),
                    .din   (cell_word[k+1]),
                    .dout  (cell_word[k])
                );
            end
        end
    endgenerate

    mt_twist u_twist (
        .cur_word  (cell_word[0]),
        .next_word (cell_word[1]),
        .far_word  (cell_word[TWIST_OFFSET]),
        .twisted   (twisted),
        .tempered  (tempered)
    );

    // Seeding recurrence: the tail cell holds the previous word, so the
    // next one is built from it directly. Word 0 is the seed itself.
    assign tail_mix  = cell_word[STATE_WORDS-1] ^ (cell_word[STATE_WORDS-1] >> 30);
    assign seed_word = (seed_cnt_reg == '0) ? seed_reg
                     : (INIT_MULT * tail_mix) + WORD_W'(seed_cnt_reg);

    // Take a new transaction only when the result register can take a word.
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_RUN) && out_free;
    assign s_accept   = s_tvalid && s_tready;
    assign do_extract = (s_accept && (s_tuser == ACT_EXTRACT) && seeded_reg)
                     || ((state_reg == ST_PEND) && out_free);
    assign shift_en   = (state_reg == ST_SEED) || do_extract;
    assign tail_in    = (state_reg == ST_SEED) ? seed_word : twisted;

    always_comb
    begin
        state_next    = state_reg;
        seed_cnt_next = seed_cnt_reg;
        seed_next     = seed_reg;
        pend_next     = pend_reg;
        seeded_next   = seeded_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (s_accept && (s_tuser == ACT_SEED))
                begin
                    // explicit seed: restart the sequence at word 0
                    seed_next     = s_tdata;
                    seed_cnt_next = '0;
                    pend_next     = 1'b0;
                    state_next    = ST_SEED;
                end
                else if (s_accept && !seeded_reg)
                begin
                    // extract before any seed: seed from the register first
                    seed_next     = default_seed_reg;
                    seed_cnt_next = '0;
                    pend_next     = 1'b1;
                    state_next    = ST_SEED;
                end
            end
            ST_SEED:
            begin
                seed_cnt_next = seed_cnt_reg + IDX_W'(1);
                if (seed_cnt_reg == LAST_IDX)
                begin
                    seeded_next = 1'b1;
                    state_next  = pend_reg ? ST_PEND : ST_RUN;
                end
            end
            ST_PEND:
            begin
                if (out_free)
                begin
                    pend_next  = 1'b0;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_RUN;
            seed_cnt_reg     <= '0;
            pend_reg         <= 1'b0;
            seeded_reg       <= 1'b0;
            default_seed_reg <= DEFAULT_SEED_RESET;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            seed_cnt_reg <= seed_cnt_next;
            pend_reg     <= pend_next;
            seeded_reg   <= seeded_next;
            if (cfg_valid)
            begin
                default_seed_reg <= cfg_data;
            end
            // Load a fresh word, or drop the one the sink just took.
            if (do_extract)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        seed_reg <= seed_next;
        if (do_extract)
        begin
            m_tdata_reg <= tempered;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Seeding ends after exactly one pass over the ring.
    `MT_ASSERT_NEXT(a_seed_ends, clk, rst_n,
        (state_reg == ST_SEED) && (seed_cnt_reg == LAST_IDX), state_reg != ST_SEED)
    // A held-back extract only waits on a fully seeded ring.
    `MT_ASSERT_NOW(a_pend_seeded, clk, rst_n, state_reg == ST_PEND, seeded_reg)
    // An accepted extract on a seeded ring shows a result the next cycle.
    `MT_ASSERT_NEXT(a_extract_out, clk, rst_n,
        s_accept && (s_tuser == ACT_EXTRACT) && seeded_reg, m_tvalid)

endmodule

`default_nettype wire
